[rtl/core/dsa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsa_pkg
// Shared types and constants for the descriptor slot allocator.
// ----------------------------------------------------------------------------
package dsa_pkg;

    localparam int MAX_SLOTS  = 1024;
    localparam int HOLE_DEPTH = 513;

    localparam int SLOT_W   = $clog2(MAX_SLOTS);
    localparam int CAP_W    = 11;
    localparam int STRIDE_W = 12;
    localparam int ADDR_W   = 64;
    localparam int HOLE_W   = $clog2(HOLE_DEPTH + 1);
    localparam int CELL_W   = $clog2(HOLE_DEPTH);
    localparam int PROD_W   = SLOT_W + STRIDE_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE     = 2'd2;

    localparam logic [CAP_W-1:0]    CAPACITY_RST = 11'd1024;
    localparam logic [STRIDE_W-1:0] STRIDE_RST   = 12'd32;
    localparam logic [ADDR_W-1:0]   BASE_RST     = 64'd0;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_RANGE     = 2'd2;
    localparam logic [1:0] STATUS_HOLE_FULL = 2'd3;

    typedef struct packed {
        logic              func;
        logic [SLOT_W-1:0] free_index;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot_index;
        logic [ADDR_W-1:0] slot_address;
    } rsp_t;

    typedef enum logic [1:0] {
        CHAIN_HOLD  = 2'b00,
        CHAIN_PUSH  = 2'b01,
        CHAIN_SHIFT = 2'b10
    } chain_op_t;

    // broadcast to every cell of the hole chain
    typedef struct packed {
        chain_op_t         op;
        logic [SLOT_W-1:0] data;
        logic              tail_we;
        logic [CELL_W-1:0] tail_idx;
    } chain_cmd_t;

endpackage
`default_nettype wire

[rtl/core/dsa_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsa_cell
// One entry of the hole stack; takes its value from a neighbor or the bus.
// ----------------------------------------------------------------------------
module dsa_cell (
    input  wire                          clk,
    input  wire  dsa_pkg::chain_cmd_t    cmd,
    input  wire                          tail_sel,
    input  wire  [dsa_pkg::SLOT_W-1:0]   prev_q,
    input  wire  [dsa_pkg::SLOT_W-1:0]   next_q,
    output logic [dsa_pkg::SLOT_W-1:0]   q
);

    logic [dsa_pkg::SLOT_W-1:0] q_reg;
    logic [dsa_pkg::SLOT_W-1:0] q_next;

    always_comb
    begin
        q_next = q_reg;
        unique case (cmd.op)
            dsa_pkg::CHAIN_PUSH:  q_next = prev_q;
            // shift toward the top; the tail cell may catch the recycled head
            dsa_pkg::CHAIN_SHIFT: q_next = tail_sel ? cmd.data : next_q;
            default:              q_next = q_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule
`default_nettype wire

[rtl/core/dsa_hole_chain.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsa_hole_chain
// Row of hole cells; cell 0 is the top of the stack.
// ----------------------------------------------------------------------------
module dsa_hole_chain (
    input  wire                          clk,
    input  wire  dsa_pkg::chain_cmd_t    cmd,
    output logic [dsa_pkg::SLOT_W-1:0]   top
);

    logic [dsa_pkg::SLOT_W-1:0] cell_q [dsa_pkg::HOLE_DEPTH];

    for (genvar i = 0; i < dsa_pkg::HOLE_DEPTH; i++)
    begin : g_cell
        logic [dsa_pkg::SLOT_W-1:0] prev_q;
        logic [dsa_pkg::SLOT_W-1:0] next_q;
        logic                       sel;

        if (i == 0)
        begin : g_first
            assign prev_q = cmd.data;
        end
        else
        begin : g_mid_prev
            assign prev_q = cell_q[i-1];
        end

        if (i == dsa_pkg::HOLE_DEPTH - 1)
        begin : g_last
            assign next_q = cell_q[i];
        end
        else
        begin : g_mid_next
            assign next_q = cell_q[i+1];
        end

        assign sel = cmd.tail_we && (cmd.tail_idx == dsa_pkg::CELL_W'(i));

        dsa_cell u_cell (
            .clk      (clk),
            .cmd      (cmd),
            .tail_sel (sel),
            .prev_q   (prev_q),
            .next_q   (next_q),
            .q        (cell_q[i])
        );
    end

    assign top = cell_q[0];

endmodule
`default_nettype wire

[rtl/core/descriptor_slot_allocator_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// descriptor_slot_allocator_top
// Slot allocator with a stack of freed holes and high-water trimming.
// ----------------------------------------------------------------------------
// Issue a request with start while busy is low; the result shows up on result
// for exactly one cycle with result_valid and cannot be held off, so the
// receiver must take it then. An allocate passes through EXEC (the multiply
// for the handle address) and ADDR (the add), and the block is free again in
// the cycle its result shows. A free gives its result from EXEC; the block
// then stays busy while the hole stack is trimmed: each pass rotates every
// held hole once through the top cell of the chain, one hole per cycle, and
// passes repeat until one removes nothing or no holes remain (no trimming
// when the free is rejected, or when it lowers the mark with no holes held).
// Configuration writes are always accepted and must only be made while the
// block is idle.
// ----------------------------------------------------------------------------
module descriptor_slot_allocator_top (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire  dsa_pkg::req_t              request,
    output logic                             result_valid,
    output dsa_pkg::rsp_t                    result,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [dsa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [dsa_pkg::CFG_DATA_W-1:0]   cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_ADDR = 4'b0100,
        ST_SCAN = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [dsa_pkg::CAP_W-1:0]    cap_reg;
    logic [dsa_pkg::STRIDE_W-1:0] stride_reg;
    logic [dsa_pkg::ADDR_W-1:0]   base_reg;

    logic                         func_reg, func_next;
    logic [dsa_pkg::SLOT_W-1:0]   fidx_reg, fidx_next;
    logic [dsa_pkg::CAP_W-1:0]    hw_reg, hw_next;
    logic [dsa_pkg::HOLE_W-1:0]   hcnt_reg, hcnt_next;
    logic [dsa_pkg::HOLE_W-1:0]   left_reg, left_next;
    logic                         removed_reg, removed_next;
    logic [dsa_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic [dsa_pkg::SLOT_W-1:0]   idx_reg, idx_next;
    logic [1:0]                   stat_reg, stat_next;
    dsa_pkg::rsp_t                rsp_reg, rsp_next;
    logic                         done_reg, done_next;

    dsa_pkg::chain_cmd_t          chain_cmd;
    logic [dsa_pkg::SLOT_W-1:0]   head;

    logic [dsa_pkg::CAP_W-1:0]    eff_cap;
    logic [dsa_pkg::CAP_W-1:0]    lim_raw;
    logic [dsa_pkg::CAP_W-1:0]    hole_lim;
    logic [dsa_pkg::CAP_W-1:0]    hw_dec;
    logic [dsa_pkg::CAP_W-1:0]    fidx_ext;
    logic                         head_match;
    logic [dsa_pkg::HOLE_W-1:0]   hcnt_after;
    logic [dsa_pkg::SLOT_W-1:0]   idx_sel;

    assign eff_cap  = (cap_reg > dsa_pkg::CAP_W'(dsa_pkg::MAX_SLOTS))
                      ? dsa_pkg::CAP_W'(dsa_pkg::MAX_SLOTS) : cap_reg;
    assign lim_raw  = (eff_cap >> 1) + dsa_pkg::CAP_W'(1);
    assign hole_lim = (lim_raw > dsa_pkg::CAP_W'(dsa_pkg::HOLE_DEPTH))
                      ? dsa_pkg::CAP_W'(dsa_pkg::HOLE_DEPTH) : lim_raw;
    assign hw_dec   = hw_reg - dsa_pkg::CAP_W'(1);
    assign fidx_ext = dsa_pkg::CAP_W'(fidx_reg);
    assign head_match = (hw_reg != '0) && (dsa_pkg::CAP_W'(head) == hw_dec);
    assign hcnt_after = head_match ? hcnt_reg - dsa_pkg::HOLE_W'(1) : hcnt_reg;

    assign busy         = (state_reg != ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = done_reg;
    assign result       = rsp_reg;

    dsa_hole_chain u_chain (
        .clk (clk),
        .cmd (chain_cmd),
        .top (head)
    );

    always_comb
    begin
        state_next   = state_reg;
        func_next    = func_reg;
        fidx_next    = fidx_reg;
        hw_next      = hw_reg;
        hcnt_next    = hcnt_reg;
        left_next    = left_reg;
        removed_next = removed_reg;
        prod_next    = prod_reg;
        idx_next     = idx_reg;
        stat_next    = stat_reg;
        rsp_next     = rsp_reg;
        done_next    = 1'b0;
        idx_sel      = '0;

        chain_cmd.op       = dsa_pkg::CHAIN_HOLD;
        chain_cmd.data     = '0;
        chain_cmd.tail_we  = 1'b0;
        chain_cmd.tail_idx = dsa_pkg::CELL_W'(hcnt_reg - dsa_pkg::HOLE_W'(1));

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    func_next  = request.func;
                    fidx_next  = request.free_index;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                if (func_reg == dsa_pkg::FUNC_ALLOC)
                begin
                    stat_next = dsa_pkg::STATUS_OK;
                    if (hcnt_reg != '0)
                    begin
                        // pop the newest hole
                        idx_sel      = head;
                        chain_cmd.op = dsa_pkg::CHAIN_SHIFT;
                        hcnt_next    = hcnt_reg - dsa_pkg::HOLE_W'(1);
                    end
                    else if (hw_reg < eff_cap)
                    begin
                        idx_sel = dsa_pkg::SLOT_W'(hw_reg);
                        hw_next = hw_reg + dsa_pkg::CAP_W'(1);
                    end
                    else
                    begin
                        stat_next = dsa_pkg::STATUS_FULL;
                    end
                    idx_next   = idx_sel;
                    prod_next  = dsa_pkg::PROD_W'(idx_sel) * dsa_pkg::PROD_W'(stride_reg);
                    state_next = ST_ADDR;
                end
                else
                begin
                    done_next             = 1'b1;
                    rsp_next.status       = dsa_pkg::STATUS_OK;
                    rsp_next.slot_index   = '0;
                    rsp_next.slot_address = '0;
                    removed_next          = 1'b0;
                    if (fidx_ext >= eff_cap)
                    begin
                        rsp_next.status = dsa_pkg::STATUS_RANGE;
                        state_next      = ST_IDLE;
                    end
                    else if ((hw_reg != '0) && (fidx_ext == hw_dec))
                    begin
                        hw_next    = hw_dec;
                        left_next  = hcnt_reg;
                        state_next = (hcnt_reg == '0) ? ST_IDLE : ST_SCAN;
                    end
                    else if (dsa_pkg::CAP_W'(hcnt_reg) >= hole_lim)
                    begin
                        rsp_next.status = dsa_pkg::STATUS_HOLE_FULL;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        chain_cmd.op   = dsa_pkg::CHAIN_PUSH;
                        chain_cmd.data = fidx_reg;
                        hcnt_next      = hcnt_reg + dsa_pkg::HOLE_W'(1);
                        left_next      = hcnt_reg + dsa_pkg::HOLE_W'(1);
                        state_next     = ST_SCAN;
                    end
                end
            end

            ST_ADDR:
            begin
                done_next           = 1'b1;
                rsp_next.status     = stat_reg;
                rsp_next.slot_index = idx_reg;
                if (stat_reg == dsa_pkg::STATUS_OK)
                begin
                    rsp_next.slot_address = base_reg + dsa_pkg::ADDR_W'(prod_reg);
                end
                else
                begin
                    rsp_next.slot_address = '0;
                end
                state_next = ST_IDLE;
            end

            ST_SCAN:
            begin
                // rotate the head out; a kept hole goes back in at the tail
                chain_cmd.op      = dsa_pkg::CHAIN_SHIFT;
                chain_cmd.data    = head;
                chain_cmd.tail_we = !head_match;
                hcnt_next         = hcnt_after;
                if (head_match)
                begin
                    hw_next = hw_dec;
                end
                left_next    = left_reg - dsa_pkg::HOLE_W'(1);
                removed_next = removed_reg || head_match;
                if (left_reg == dsa_pkg::HOLE_W'(1))
                begin
                    if ((removed_reg || head_match) && (hcnt_after != '0))
                    begin
                        left_next    = hcnt_after;
                        removed_next = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            hw_reg      <= '0;
            hcnt_reg    <= '0;
            left_reg    <= '0;
            removed_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            hw_reg      <= hw_next;
            hcnt_reg    <= hcnt_next;
            left_reg    <= left_next;
            removed_reg <= removed_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        fidx_reg <= fidx_next;
        prod_reg <= prod_next;
        idx_reg  <= idx_next;
        stat_reg <= stat_next;
        rsp_reg  <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= dsa_pkg::CAPACITY_RST;
            stride_reg <= dsa_pkg::STRIDE_RST;
            base_reg   <= dsa_pkg::BASE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dsa_pkg::CFG_CAPACITY: cap_reg    <= cfg_data[dsa_pkg::CAP_W-1:0];
                dsa_pkg::CFG_STRIDE:   stride_reg <= cfg_data[dsa_pkg::STRIDE_W-1:0];
                dsa_pkg::CFG_BASE:     base_reg   <= cfg_data[dsa_pkg::ADDR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[rtl/core/dsa_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsa_checker
// Port-level checks for the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module dsa_checker (
    input wire                clk,
    input wire                rst_n,
    input wire                start,
    input wire                busy,
    input wire                result_valid,
    input wire dsa_pkg::rsp_t result
);

    // each item gives one result, never two back to back
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held for two cycles");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // an idle block with no request produces nothing
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !start) |=> !result_valid)
        else $error("result without an accepted item");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status != dsa_pkg::STATUS_OK))
        |-> ((result.slot_index == '0) && (result.slot_address == '0)))
        else $error("error result carries a slot");

endmodule

bind descriptor_slot_allocator_top dsa_checker u_dsa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);
`default_nettype wire
